// ===== hw/rtl/repeating_digit_key_letter_shift_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the repeating digit key letter shift core
// Shared concurrent assertion forms, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef REPEATING_DIGIT_KEY_LETTER_SHIFT_CORE_ASSERT_SVH
`define REPEATING_DIGIT_KEY_LETTER_SHIFT_CORE_ASSERT_SVH

// Assertion that is switched off while the synchronous reset is held low.
`define RDKLS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Assertion that also holds during reset.
`define RDKLS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/rdkls_pkg.sv =====
// ----------------------------------------------------------------------------
// Repeating digit key letter shift package
// Types, codes and sizes shared by the cipher core and its stages.
// ----------------------------------------------------------------------------
`default_nettype none

package rdkls_pkg;

    localparam int KEY_DEPTH = 32;
    localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KEY_CW    = $clog2(KEY_DEPTH + 1);

    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 3;
    localparam int DIGIT_W  = 4;
    localparam int TDATA_W  = 16;
    localparam int ALPHA_N  = 26;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CIPHER = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_KEY  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_TEXT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7a;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5a;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic [CMD_W-1:0]  command;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CHAR_W-1:0]   char_out;
    } t_result;

    // Handshake between the input stage and the result stage.
    typedef struct packed {
        logic valid;
        logic advance;
    } t_stage_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/rdkls_in_stage.sv =====
// ----------------------------------------------------------------------------
// Input register stage
// Captures one command beat and holds it until the result stage moves it on.
// ----------------------------------------------------------------------------
`default_nettype none

module rdkls_in_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire rdkls_pkg::t_item i_item,
    input  wire logic           i_advance,
    output logic                o_valid,
    output rdkls_pkg::t_item    o_item
);
    import rdkls_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  n_valid;

    // A held beat that is moving on this cycle frees the register.
    assign o_ready = !r_valid || i_advance;
    assign n_valid = (i_valid && o_ready) ? 1'b1 : (i_advance ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== hw/rtl/rdkls_cipher.sv =====
// ----------------------------------------------------------------------------
// Key store and letter shift
// Holds the key digits, count and pointer, and works out one result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "repeating_digit_key_letter_shift_core_assert.svh"

module rdkls_cipher (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire rdkls_pkg::t_stage_ctl i_ctl,
    input  wire rdkls_pkg::t_item    i_item,
    output rdkls_pkg::t_result       o_result
);
    import rdkls_pkg::*;

    logic [DIGIT_W-1:0] r_key [KEY_DEPTH];
    logic [KEY_CW-1:0]  r_count;
    logic [KEY_AW-1:0]  r_ptr;
    logic [KEY_CW-1:0]  n_count;
    logic [KEY_AW-1:0]  n_ptr;

    logic               key_ok;
    logic               full;
    logic               key_wr;
    logic [KEY_AW-1:0]  idx;
    logic [KEY_CW-1:0]  idx_p1;
    logic [DIGIT_W-1:0] digit;
    logic [CHAR_W:0]    sum;
    logic               is_lower;
    logic               is_upper;
    logic [CHAR_W-1:0]  hi_bound;
    logic [CHAR_W-1:0]  shifted;

    assign key_ok   = (i_item.char_in > CH_ZERO) && (i_item.char_in < CH_NINE);
    assign full     = (r_count >= KEY_CW'(KEY_DEPTH));
    // A stale pointer beyond the count falls back to the first digit.
    assign idx      = (KEY_CW'(r_ptr) < r_count) ? r_ptr : '0;
    assign idx_p1   = KEY_CW'(idx) + KEY_CW'(1);
    assign digit    = r_key[idx];
    assign is_lower = (i_item.char_in >= CH_LO_A) && (i_item.char_in <= CH_LO_Z);
    assign is_upper = (i_item.char_in >= CH_UP_A) && (i_item.char_in <= CH_UP_Z);
    assign hi_bound = is_lower ? CH_LO_Z : CH_UP_Z;
    assign sum      = {1'b0, i_item.char_in} + (CHAR_W + 1)'(digit);
    assign shifted  = (sum > {1'b0, hi_bound}) ? CHAR_W'(sum - (CHAR_W + 1)'(ALPHA_N))
                                               : sum[CHAR_W-1:0];

    always_comb begin
        n_count           = r_count;
        n_ptr             = r_ptr;
        key_wr            = 1'b0;
        o_result.char_out = '0;
        o_result.status   = ST_OK;
        case (i_item.command)
            CMD_CLEAR: begin
                n_count = '0;
                n_ptr   = '0;
            end
            CMD_LOAD: begin
                if (!key_ok) begin
                    o_result.status = ST_BAD_KEY;
                end else if (full) begin
                    o_result.status = ST_FULL;
                end else begin
                    key_wr  = 1'b1;
                    n_count = r_count + KEY_CW'(1);
                end
            end
            CMD_CIPHER: begin
                if (r_count == '0) begin
                    o_result.status = ST_EMPTY;
                end else begin
                    n_ptr = (idx_p1 >= r_count) ? '0 : idx_p1[KEY_AW-1:0];
                    if (is_lower || is_upper) begin
                        o_result.char_out = shifted;
                    end else begin
                        o_result.status = ST_BAD_TEXT;
                    end
                end
            end
            default: begin
                o_result.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
        end else if (i_ctl.advance) begin
            r_count <= n_count;
            r_ptr   <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance && key_wr) begin
            r_key[r_count[KEY_AW-1:0]] <= DIGIT_W'(i_item.char_in - CH_ZERO);
        end
    end

    `RDKLS_ASSERT(a_ptr_in_range, i_clk, i_rst_n,
        (r_count == '0) ? (r_ptr == '0) : (KEY_CW'(r_ptr) < r_count),
        "key pointer outside the stored key")
    `RDKLS_ASSERT(a_clear_empties, i_clk, i_rst_n,
        (i_ctl.advance && i_item.command == CMD_CLEAR) |=> (r_count == '0),
        "clear did not empty the key store")
    `RDKLS_ASSERT(a_load_grows, i_clk, i_rst_n,
        (i_ctl.advance && i_item.command == CMD_LOAD && o_result.status == ST_OK)
            |=> (r_count == $past(r_count) + KEY_CW'(1)),
        "accepted key digit did not grow the count")
    `RDKLS_ASSERT(a_advance_needs_beat, i_clk, i_rst_n,
        i_ctl.advance |-> i_ctl.valid,
        "result stage advanced without a held beat")
    `RDKLS_ASSERT_ALWAYS(a_count_bound, i_clk,
        !i_rst_n || (r_count <= KEY_CW'(KEY_DEPTH)),
        "key count beyond the store depth")

endmodule

`default_nettype wire

// ===== hw/rtl/rdkls_out_stage.sv =====
// ----------------------------------------------------------------------------
// Result register stage
// Holds one finished result until the downstream side takes the beat.
// ----------------------------------------------------------------------------
`default_nettype none

module rdkls_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire rdkls_pkg::t_result i_result,
    input  wire logic             i_ready,
    output rdkls_pkg::t_stage_ctl o_ctl,
    output logic                  o_valid,
    output rdkls_pkg::t_result    o_result
);
    import rdkls_pkg::*;

    logic    r_valid;
    t_result r_result;
    logic    advance;

    // The held result either leaves this cycle or the register is empty.
    assign advance       = i_valid && (!r_valid || i_ready);
    assign o_ctl.valid   = i_valid;
    assign o_ctl.advance = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== hw/rtl/repeating_digit_key_letter_shift_core.sv =====
// ----------------------------------------------------------------------------
// Repeating digit key letter shift core
//
//   Channel   Dir  tdata fields (low bit up)            Beat
//   s_axis    in   command[1:0], char_in[9:2], zeros   one command
//   m_axis    out  char_out[7:0], status[10:8], zeros  one result per command
//
// One beat in, one beat out; a new command is taken every cycle while m_axis does not stall.
// A command passes through the input register, then the key lookup and shift
// into the result register. Reset is synchronous and empties the key store.
// A stall on m_axis holds the result register and, once the input register
// is also full, drops s_axis_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module repeating_digit_key_letter_shift_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // command[1:0], char_in[9:2]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // char_out[7:0], status[10:8]
);
    import rdkls_pkg::*;

    t_item      in_item;
    t_item      held_item;
    logic       held_valid;
    t_result    result;
    t_result    out_result;
    t_stage_ctl ctl;

    assign in_item.command = s_axis_tdata[CMD_W-1:0];
    assign in_item.char_in = s_axis_tdata[CMD_W+CHAR_W-1:CMD_W];

    rdkls_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (ctl.advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    rdkls_cipher u_cipher (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_item   (held_item),
        .o_result (result)
    );

    rdkls_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (held_valid),
        .i_result (result),
        .i_ready  (m_axis_tready),
        .o_ctl    (ctl),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result)
    );

    assign m_axis_tdata = {{(TDATA_W - CHAR_W - STATUS_W){1'b0}},
                           out_result.status, out_result.char_out};

endmodule

`default_nettype wire

// ===== bench/shift_cipher_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letter shift cipher checker
// Watches both stream channels of the cipher core. Every command beat taken
// on the input side is run through a local model of the key store and the
// letter shift. The outcome is queued, and each result beat is compared
// field by field against the oldest queued outcome.
// ----------------------------------------------------------------------------

module shift_cipher_checker
    import rdkls_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [TDATA_W-1:0]   i_s_tdata,    // command[1:0], char_in[9:2]
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [TDATA_W-1:0]   i_m_tdata,    // char_out[7:0], status[10:8]
    output int                   o_errors,
    output int                   o_pending
);

    localparam int RESULT_W     = STATUS_W + CHAR_W;
    localparam int ITEM_W       = CMD_W + CHAR_W;
    localparam int REPORT_LIMIT = 40;

    logic [DIGIT_W-1:0] key_store [KEY_DEPTH];
    logic [KEY_CW-1:0]  key_len;
    logic [KEY_AW-1:0]  key_pos;
    t_result            cipher_out_q [$];
    int                 n_errors;

    function automatic t_result cipher_predict(t_item beat);
        t_result           res;
        logic [KEY_AW-1:0] idx;
        logic [KEY_CW-1:0] idx_p1;
        int                sum;
        int                lo;
        int                hi;
        res.char_out = '0;
        res.status   = ST_OK;
        case (beat.command)
            CMD_CLEAR: begin
                key_len = '0;
                key_pos = '0;
            end
            CMD_LOAD: begin
                // The digit test comes before the full test.
                if (!(beat.char_in > CH_ZERO && beat.char_in < CH_NINE)) begin
                    res.status = ST_BAD_KEY;
                end else if (key_len >= KEY_CW'(KEY_DEPTH)) begin
                    res.status = ST_FULL;
                end else begin
                    key_store[key_len[KEY_AW-1:0]] = DIGIT_W'(beat.char_in - CH_ZERO);
                    key_len = key_len + KEY_CW'(1);
                end
            end
            CMD_CIPHER: begin
                if (key_len == '0) begin
                    res.status = ST_EMPTY;
                end else begin
                    idx    = (KEY_CW'(key_pos) < key_len) ? key_pos : '0;
                    idx_p1 = KEY_CW'(idx) + KEY_CW'(1);
                    sum    = int'(beat.char_in) + int'(key_store[idx]);
                    // A non-letter still uses up its key digit.
                    key_pos = (idx_p1 >= key_len) ? '0 : idx_p1[KEY_AW-1:0];
                    if (beat.char_in >= CH_LO_A && beat.char_in <= CH_LO_Z) begin
                        lo = int'(CH_LO_A);
                        hi = int'(CH_LO_Z);
                    end else if (beat.char_in >= CH_UP_A && beat.char_in <= CH_UP_Z) begin
                        lo = int'(CH_UP_A);
                        hi = int'(CH_UP_Z);
                    end else begin
                        res.status = ST_BAD_TEXT;
                    end
                    if (res.status == ST_OK) begin
                        if (sum > hi) begin
                            sum = lo + (sum - hi - 1);
                        end
                        res.char_out = CHAR_W'(sum);
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic void flag_mismatch(string field, int want, int got);
        n_errors++;
        if (n_errors <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            key_len = '0;
            key_pos = '0;
            cipher_out_q.delete();
            n_errors = 0;
        end else begin
            // Results are checked before the input beat of the same edge is
            // queued; that beat cannot have produced a result yet.
            if (i_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
                seen = i_m_tdata[RESULT_W-1:0];
                if (cipher_out_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= REPORT_LIMIT) begin
                        $display("%0t: result beat with none expected, actual %0h",
                                 $realtime, i_m_tdata);
                    end
                end else begin
                    want = cipher_out_q.pop_front();
                    if (seen.char_out !== want.char_out) begin
                        flag_mismatch("char_out", int'(want.char_out), int'(seen.char_out));
                    end
                    if (seen.status !== want.status) begin
                        flag_mismatch("status", int'(want.status), int'(seen.status));
                    end
                    if (i_m_tdata[TDATA_W-1:RESULT_W] !== '0) begin
                        flag_mismatch("tdata padding", 0,
                                      int'(i_m_tdata[TDATA_W-1:RESULT_W]));
                    end
                end
            end
            if (i_s_tvalid === 1'b1 && i_s_tready === 1'b1) begin
                cipher_out_q.push_back(cipher_predict(i_s_tdata[ITEM_W-1:0]));
            end
        end
        o_errors  <= n_errors;
        o_pending <= cipher_out_q.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letter shift cipher core testbench
// Drives clear, load and cipher commands into the core: a directed opening on
// the boundary characters and error cases, a back-pressure phase, then random
// key-and-text sequences mixed with noise. Both channels idle at random.
// Checking is done by the checker instance beside the core.
// ----------------------------------------------------------------------------

module tb_top;
    import rdkls_pkg::*;

    localparam int          RANDOM_ITEMS = 600;
    localparam int          LONG_HOLD    = 64;
    localparam int          TAIL_CYCLES  = 8;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    // Command code that the core answers with an OK result and no state change.
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;   // command[1:0], char_in[9:2]
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;        // char_out[7:0], status[10:8]

    int errors;
    int pending;
    int sent;
    int burst_left;
    bit steady;
    int hold_seq = 0;

    repeating_digit_key_letter_shift_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    shift_cipher_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    initial begin
        int unsigned n_cycles;
        n_cycles = 0;
        while (n_cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            n_cycles++;
        end
        $display("[repeating_digit_key_letter_shift_core] ERROR");
        $finish;
    end

    // Receiver: changes its stall pattern at random intervals, and holds
    // off completely whenever the stimulus asks for a long stall.
    initial begin
        int  mode;
        int  mode_left;
        int  hold_left;
        int  seen_seq;
        int  phase;
        bit  rdy;
        mode_left = 0;
        hold_left = 0;
        seen_seq  = 0;
        phase     = 0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != seen_seq) begin
                seen_seq  = hold_seq;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (mode)
                    0: rdy = 1'b1;
                    1: rdy = ($urandom_range(0, 3) != 0);
                    2: rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = (phase % 3 == 0);
                endcase
            end
            m_axis_tready <= rdy;
        end
    end

    function automatic logic [CHAR_W-1:0] pick_letter();
        if ($urandom_range(0, 1) == 1) begin
            return CH_LO_A + CHAR_W'($urandom_range(0, ALPHA_N - 1));
        end
        return CH_UP_A + CHAR_W'($urandom_range(0, ALPHA_N - 1));
    endfunction

    function automatic logic [CHAR_W-1:0] pick_digit();
        return CH_ZERO + CHAR_W'($urandom_range(1, 8));
    endfunction

    // Any byte, weighted towards letters, digits and the edges of both ranges.
    function automatic logic [CHAR_W-1:0] pick_noise_char();
        case ($urandom_range(0, 3))
            0: return CHAR_W'($urandom_range(0, 255));
            1: return CH_ZERO + CHAR_W'($urandom_range(0, 9));
            2: return pick_letter();
            default: begin
                case ($urandom_range(0, 5))
                    0: return CH_UP_A - 1'b1;
                    1: return CH_UP_Z + 1'b1;
                    2: return CH_LO_A - 1'b1;
                    3: return CH_LO_Z + 1'b1;
                    4: return 8'hff;
                    default: return 8'h00;
                endcase
            end
        endcase
    endfunction

    // Offers one beat and returns at the edge where it is taken. Outside the
    // steady phase the sender works in bursts with idle gaps between them.
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch);
        t_item beat;
        int    gap;
        beat.command = cmd;
        beat.char_in = ch;
        if (!steady && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(TDATA_W - CMD_W - CHAR_W){1'b0}}, beat};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        if (cmd != CMD_SPARE) begin
            sent++;
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int  kind;
        int  n;
        int  r;
        bit  mid_pause_done;
        sent           = 0;
        burst_left     = 0;
        steady         = 1'b0;
        mid_pause_done = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: empty key, rejected key bytes, wrap-around,
        // non-letters next to both alphabets, the ignored command, clear.
        send_beat(CMD_CIPHER, CH_LO_A);
        send_beat(CMD_LOAD, CH_ZERO);
        send_beat(CMD_LOAD, CH_NINE);
        send_beat(CMD_LOAD, 8'hff);
        send_beat(CMD_LOAD, 8'h00);
        send_beat(CMD_LOAD, CH_ZERO + 8'd1);
        send_beat(CMD_LOAD, CH_ZERO + 8'd8);
        send_beat(CMD_CIPHER, CH_LO_Z);
        send_beat(CMD_CIPHER, CH_UP_Z);
        send_beat(CMD_CIPHER, CH_UP_A);
        send_beat(CMD_CIPHER, CH_LO_Z - 8'd1);
        send_beat(CMD_CIPHER, CH_UP_A - 8'd1);
        send_beat(CMD_CIPHER, CH_UP_Z + 8'd1);
        send_beat(CMD_CIPHER, CH_LO_A - 8'd1);
        send_beat(CMD_CIPHER, CH_LO_Z + 8'd1);
        send_beat(CMD_CIPHER, 8'hff);
        send_beat(CMD_CIPHER, 8'h00);
        send_beat(CMD_SPARE, 8'hff);
        send_beat(CMD_LOAD, CH_ZERO + 8'd5);
        send_beat(CMD_CIPHER, CH_LO_A + 8'd12);
        send_beat(CMD_CIPHER, CH_UP_A + 8'd12);
        send_beat(CMD_CLEAR, 8'haa);
        send_beat(CMD_CIPHER, CH_LO_A + 8'd16);
        send_beat(CMD_SPARE, 8'h00);
        send_beat(CMD_LOAD, CH_ZERO + 8'd4);

        // Back-pressure: the receiver stalls for a long stretch while the
        // sender keeps offering beats without a gap.
        wait_drained();
        hold_seq <= hold_seq + 1;
        steady = 1'b1;
        send_beat(CMD_LOAD, pick_digit());
        for (int i = 0; i < 24; i++) begin
            send_beat(CMD_CIPHER, pick_letter());
        end
        steady = 1'b0;

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (!mid_pause_done && sent >= RANDOM_ITEMS / 2) begin
                wait_drained();
                mid_pause_done = 1'b1;
            end
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                // Key then text, with the odd late key digit or non-letter.
                send_beat(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)));
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, KEY_DEPTH)
                                                 : $urandom_range(1, 8);
                repeat (n) send_beat(CMD_LOAD, pick_digit());
                n = $urandom_range(4, 30);
                repeat (n) begin
                    r = $urandom_range(0, 19);
                    if (r == 0) begin
                        send_beat(CMD_LOAD, pick_digit());
                    end else if (r == 1) begin
                        send_beat(CMD_CIPHER, pick_noise_char());
                    end else begin
                        send_beat(CMD_CIPHER, pick_letter());
                    end
                end
            end else if (kind == 6) begin
                // Fill the key store and push past the end of it.
                send_beat(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)));
                repeat (KEY_DEPTH) send_beat(CMD_LOAD, pick_digit());
                n = $urandom_range(1, 3);
                repeat (n) send_beat(CMD_LOAD, pick_noise_char());
                n = $urandom_range(2, 10);
                repeat (n) send_beat(CMD_CIPHER, pick_letter());
            end else begin
                n = $urandom_range(4, 16);
                repeat (n) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_beat(CMD_CLEAR, pick_noise_char());
                    end else begin
                        send_beat(CMD_SPARE - CMD_W'($urandom_range(0, 2)),
                                  pick_noise_char());
                    end
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[repeating_digit_key_letter_shift_core] OK");
        end else begin
            $display("[repeating_digit_key_letter_shift_core] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rdkls_pkg.sv
hw/rtl/rdkls_in_stage.sv
hw/rtl/rdkls_cipher.sv
hw/rtl/rdkls_out_stage.sv
hw/rtl/repeating_digit_key_letter_shift_core.sv
bench/shift_cipher_checker.sv
bench/tb_top.sv
